// ===== rtl/sparse_row_accumulate_store_top_assert.svh =====
// assertion macros for the sparse row accumulate store
// used by sparse_row_accumulate_store_top, expects clk and arst_n in scope
`ifndef SPARSE_ROW_ACCUMULATE_STORE_TOP_ASSERT_SVH
`define SPARSE_ROW_ACCUMULATE_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define SRAS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sras assertion failed");

// next-cycle implication
`define SRAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sras assertion failed");

`endif

// ===== rtl/sras_pkg.sv =====
// shared types and constants of the sparse row accumulate store
// no dependencies
package sras_pkg;

	localparam int ROW_W = 8;
	localparam int COL_W = 8;
	localparam int VAL_W = 64;
	localparam int THR_W = 63;
	localparam int ROW_LIMIT = 1 << ROW_W;

	localparam int ROW_COUNT_DEF = 256;
	localparam int COL_COUNT_DEF = 256;
	localparam int SLOTS_PER_ROW_DEF = 16;

	localparam int APB_DW = 64;
	localparam int APB_AW = 4;
	localparam logic REG_DROP_THR = 1'b0;
	localparam logic [THR_W-1:0] DROP_THR_RST = 63'd1;

	localparam logic OP_ACC = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DROP = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	typedef struct packed {
		logic op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic signed [VAL_W-1:0] value;
	} sras_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic found;
		logic [1:0] status;
	} sras_res_t;

endpackage

// ===== rtl/sras_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sras_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/sparse_row_accumulate_store_top.sv =====
// sparse row accumulate store: top level with sequencer, slot ram and row fill ram
// depends on sras_pkg, sras_ram and sparse_row_accumulate_store_top_assert.svh
//
// requests arrive on req_valid / req_stall / req_data: op 0 accumulates value into
// (row, col), op 1 reads it back. each request gives one result on res_valid /
// res_stall / res_data (read_value, found, status).
// drop_threshold sits at byte address 0 of the 64-bit apb port; write it only
// while no request is in flight.
// the block takes one request at a time and holds req_stall high until the
// result has moved into the output register. the row search reads one slot per
// cycle from the slot ram and compares its column tag. a dropped or out-of-range
// request skips the search, and a hit on an accumulate goes through the add
// state for the saturating add and write-back.
// while res_stall is high the result in the output register stays there, and a
// newly finished result waits in the done state until it can move in; the next
// request is taken once it has moved.
// after reset every row is empty (per-row valid bits, no clearing pass) and
// drop_threshold is 1, so only an exact zero is dropped.
`include "sparse_row_accumulate_store_top_assert.svh"

module sparse_row_accumulate_store_top
	import sras_pkg::*;
#(
	parameter int ROW_COUNT = ROW_COUNT_DEF,
	parameter int COL_COUNT = COL_COUNT_DEF,
	parameter int SLOTS_PER_ROW = SLOTS_PER_ROW_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready,
	input logic req_valid,
	output logic req_stall,
	input sras_req_t req_data,
	output logic res_valid,
	input logic res_stall,
	output sras_res_t res_data
);

	localparam int ROWS_EFF = (ROW_COUNT > ROW_LIMIT) ? ROW_LIMIT : ROW_COUNT;
	localparam int SLOT_DEPTH = ROWS_EFF * SLOTS_PER_ROW;
	localparam int RA_W = (ROWS_EFF > 1) ? $clog2(ROWS_EFF) : 1;
	localparam int SA_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int FILL_W = $clog2(SLOTS_PER_ROW + 1);
	localparam int SLOT_W = COL_W + VAL_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAG = 3'd1;
	localparam logic [2:0] S_DROP = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_ADD = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [THR_W-1:0] thr_q;
	logic [ROWS_EFF-1:0] vld_q;
	logic out_valid_q;
	logic cmp_v_q;

	sras_req_t req_q;
	sras_res_t res_q;
	sras_res_t out_q;
	logic row_vld_q;
	logic in_range_q;
	logic [VAL_W-1:0] mag_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] idx_q;
	logic [SA_W-1:0] base_q;
	logic [SA_W-1:0] cmp_addr_q;

	logic cfg_wr;
	logic req_accept;
	logic out_free;
	logic [RA_W-1:0] row_idx;
	logic hit;
	logic srch_end;
	logic append;
	logic [COL_W-1:0] slot_col_rd;
	logic [VAL_W-1:0] slot_val_rd;
	logic [VAL_W-1:0] sum;
	logic ovf;
	logic [VAL_W-1:0] sat_val;
	logic [VAL_W-1:0] add_val;

	logic slot_we;
	logic [SA_W-1:0] slot_waddr;
	logic [SLOT_W-1:0] slot_wdata;
	logic slot_re;
	logic [SA_W-1:0] slot_raddr;
	logic [SLOT_W-1:0] slot_rdata;

	logic fill_we;
	logic [FILL_W-1:0] fill_wdata;
	logic [RA_W-1:0] fill_raddr;
	logic [FILL_W-1:0] fill_rdata;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_DROP_THR);
	assign prdata = (paddr[3] == REG_DROP_THR) ? {1'b0, thr_q} : '0;

	// request and result handshake
	assign req_stall = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign res_valid = out_valid_q;
	assign res_data = out_q;
	assign out_free = !out_valid_q || !res_stall;

	// row search datapath
	assign row_idx = RA_W'(req_q.row);
	assign slot_col_rd = slot_rdata[SLOT_W-1:VAL_W];
	assign slot_val_rd = slot_rdata[VAL_W-1:0];
	assign hit = (state_q == S_SRCH) && cmp_v_q && (slot_col_rd == req_q.col);
	assign srch_end = (state_q == S_SRCH) && !hit && (idx_q == fill_q);
	assign slot_re = (state_q == S_SRCH) && !hit && !srch_end;
	assign slot_raddr = base_q + SA_W'(idx_q);
	assign append = srch_end && (req_q.op == OP_ACC)
		&& (fill_q < FILL_W'(SLOTS_PER_ROW));

	// saturating add
	assign sum = slot_val_rd + $unsigned(req_q.value);
	assign ovf = ~(slot_val_rd[VAL_W-1] ^ req_q.value[VAL_W-1])
		& (slot_val_rd[VAL_W-1] ^ sum[VAL_W-1]);
	assign sat_val = slot_val_rd[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
		: {1'b0, {(VAL_W-1){1'b1}}};
	assign add_val = ovf ? sat_val : sum;

	assign slot_we = append || (state_q == S_ADD);
	assign slot_waddr = (state_q == S_ADD) ? cmp_addr_q : slot_raddr;
	assign slot_wdata = (state_q == S_ADD) ? {req_q.col, add_val}
		: {req_q.col, $unsigned(req_q.value)};

	assign fill_we = append;
	assign fill_wdata = FILL_W'(fill_q + 1'b1);
	assign fill_raddr = RA_W'(req_data.row);

	sras_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOT_DEPTH)
	) u_slot_ram (
		.clk(clk),
		.we(slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re(slot_re),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	sras_ram #(
		.WIDTH(FILL_W),
		.DEPTH(ROWS_EFF)
	) u_fill_ram (
		.clk(clk),
		.we(fill_we),
		.waddr(row_idx),
		.wdata(fill_wdata),
		.re(req_accept),
		.raddr(fill_raddr),
		.rdata(fill_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q <= DROP_THR_RST;
			vld_q <= '0;
			out_valid_q <= 1'b0;
			cmp_v_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				thr_q <= pwdata[THR_W-1:0];
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					state_q <= S_DROP;
				end
				S_DROP: begin
					cmp_v_q <= 1'b0;
					if (req_q.op == OP_READ) begin
						state_q <= in_range_q ? S_SRCH : S_DONE;
					end else if ((mag_q < {1'b0, thr_q}) || !in_range_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (hit) begin
						state_q <= (req_q.op == OP_ACC) ? S_ADD : S_DONE;
					end else if (srch_end) begin
						state_q <= S_DONE;
					end else begin
						cmp_v_q <= 1'b1;
					end
					if (append) begin
						vld_q[row_idx] <= 1'b1;
					end
				end
				S_ADD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and working registers
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= req_data;
			row_vld_q <= vld_q[RA_W'(req_data.row)];
		end
		case (state_q)
			S_MAG: begin
				mag_q <= req_q.value[VAL_W-1] ? (VAL_W'(0) - $unsigned(req_q.value))
					: $unsigned(req_q.value);
				fill_q <= row_vld_q ? fill_rdata : '0;
				base_q <= SA_W'(row_idx) * SA_W'(SLOTS_PER_ROW);
				in_range_q <= ({{(32-ROW_W){1'b0}}, req_q.row} < 32'(ROW_COUNT))
					&& ({{(32-COL_W){1'b0}}, req_q.col} < 32'(COL_COUNT));
			end
			S_DROP: begin
				idx_q <= '0;
				res_q.read_value <= '0;
				res_q.found <= 1'b0;
				if (req_q.op == OP_READ) begin
					res_q.status <= ST_DONE;
				end else if (mag_q < {1'b0, thr_q}) begin
					res_q.status <= ST_DROP;
				end else if (!in_range_q) begin
					res_q.status <= ST_REJECT;
				end else begin
					res_q.status <= ST_DONE;
				end
			end
			S_SRCH: begin
				if (hit) begin
					if (req_q.op == OP_READ) begin
						res_q.read_value <= $signed(slot_val_rd);
						res_q.found <= 1'b1;
					end
				end else if (srch_end) begin
					if ((req_q.op == OP_ACC) && !append) begin
						res_q.status <= ST_REJECT;
					end
				end else begin
					idx_q <= FILL_W'(idx_q + 1'b1);
					cmp_addr_q <= slot_raddr;
				end
			end
			S_ADD: begin
				res_q.found <= 1'b1;
				res_q.status <= ovf ? ST_SAT : ST_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	`SRAS_ASSERT_NEXT(a_done_loads_out, (state_q == S_DONE) && out_free, out_valid_q && (state_q == S_IDLE))
	`SRAS_ASSERT_NOW(a_fill_bound, fill_we, fill_wdata <= FILL_W'(SLOTS_PER_ROW))
	`SRAS_ASSERT_NOW(a_slot_write_ok, slot_we, in_range_q && (req_q.op == OP_ACC) && ((state_q == S_ADD) || (state_q == S_SRCH)))

endmodule

// ===== bench/sras_checker.sv =====
// result checker for the sparse row accumulate store: predicts every result
// from the accepted requests and register writes, then compares it field by field
// depends on sras_pkg
`timescale 1ns / 100ps

module sras_result_checker
	import sras_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic req_valid,
	input logic req_stall,
	input sras_req_t req_data,
	input logic res_valid,
	input logic res_stall,
	input sras_res_t res_data,
	output int fails,
	output int pending,
	output int checked
);

	localparam int EXP_DEPTH = 8;

	logic [COL_W-1:0] tag_mem [ROW_COUNT_DEF][SLOTS_PER_ROW_DEF];
	logic [VAL_W-1:0] val_mem [ROW_COUNT_DEF][SLOTS_PER_ROW_DEF];
	int unsigned row_len [ROW_COUNT_DEF];
	logic [THR_W-1:0] drop_thr;
	sras_res_t exp_fifo [EXP_DEPTH];
	int exp_head;
	int exp_count;
	sras_res_t want;

	function automatic sras_res_t apply_request(input sras_req_t r);
		sras_res_t o;
		int hit;
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] mag;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] s;
		o = '0;
		hit = -1;
		v = r.value;
		for (int i = 0; i < row_len[r.row]; i++) begin
			if (hit < 0 && tag_mem[r.row][i] == r.col) begin
				hit = i;
			end
		end
		if (r.op == OP_READ) begin
			if (hit >= 0) begin
				o.read_value = val_mem[r.row][hit];
				o.found = 1'b1;
			end
		end else begin
			mag = v[VAL_W-1] ? (64'd0 - v) : v;
			if (mag < {1'b0, drop_thr}) begin
				o.status = ST_DROP;
			end else if (hit >= 0) begin
				a = val_mem[r.row][hit];
				s = a + v;
				o.found = 1'b1;
				if (a[VAL_W-1] == v[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
					s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
					o.status = ST_SAT;
				end
				val_mem[r.row][hit] = s;
			end else if (row_len[r.row] >= SLOTS_PER_ROW_DEF) begin
				o.status = ST_REJECT;
			end else begin
				tag_mem[r.row][row_len[r.row]] = r.col;
				val_mem[r.row][row_len[r.row]] = v;
				row_len[r.row]++;
				o.status = ST_DONE;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_COUNT_DEF; i++) begin
				row_len[i] = 0;
			end
			drop_thr = DROP_THR_RST;
			exp_head = 0;
			exp_count = 0;
			fails = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (exp_count == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					want = exp_fifo[exp_head];
					exp_head = (exp_head + 1) % EXP_DEPTH;
					exp_count--;
					if (res_data.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h", want.read_value,
							res_data.read_value);
						fails++;
					end
					if (res_data.found !== want.found) begin
						$error("found: expected %b, got %b", want.found, res_data.found);
						fails++;
					end
					if (res_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_data.status);
						fails++;
					end
					checked++;
				end
			end
			if (psel && penable && pwrite && pready
				&& (paddr >> 3) == APB_AW'(REG_DROP_THR)) begin
				drop_thr = pwdata[THR_W-1:0];
			end
			if (req_valid && !req_stall) begin
				if (exp_count >= EXP_DEPTH) begin
					$error("too many requests outstanding");
					fails++;
				end else begin
					exp_fifo[(exp_head + exp_count) % EXP_DEPTH] = apply_request(req_data);
					exp_count++;
				end
			end
			pending = exp_count;
		end
	end

endmodule

// ===== bench/tb.sv =====
// testbench top for the sparse row accumulate store: clock, reset, request and
// result traffic, drop threshold writes and the final verdict
// depends on sras_pkg, sras_result_checker and sparse_row_accumulate_store_top
`timescale 1ns / 100ps

module tb;
	import sras_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 305;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic req_valid;
	logic req_stall;
	sras_req_t req_data;
	logic res_valid;
	logic res_stall;
	sras_res_t res_data;

	int fails;
	int pending;
	int checked;
	int sent;
	int cycle_count;
	int hold_len;
	bit steady;
	logic [THR_W-1:0] cur_thr;

	sparse_row_accumulate_store_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	sras_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.fails(fails),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic sras_req_t mk_request(input logic op, input int row, input int col,
		input logic [VAL_W-1:0] value);
		sras_req_t r;
		r.op = op;
		r.row = ROW_W'(row);
		r.col = COL_W'(col);
		r.value = value;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] rand_amount();
		logic [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] w;
		case ($urandom_range(0, 7))
			0: begin
				v = {$urandom, $urandom};
			end
			1: begin
				v = VAL_W'(int'($urandom_range(0, 2000)) - 1000);
			end
			2: begin
				case ($urandom_range(0, 4))
					0: v = {1'b0, {(VAL_W-1){1'b1}}};
					1: v = {1'b1, {(VAL_W-1){1'b0}}};
					2: v = '0;
					3: v = 64'd1;
					default: v = '1;
				endcase
			end
			3: begin
				v = {1'b0, cur_thr} + 64'($urandom_range(0, 2)) - 64'd1;
				if ($urandom_range(0, 1)) begin
					v = 64'd0 - v;
				end
			end
			4, 5: begin
				w = {$urandom, $urandom};
				v = w >>> $urandom_range(1, 60);
			end
			default: begin
				v = {32'(int'($urandom_range(0, 40)) - 20), $urandom & 32'hC000_0000};
			end
		endcase
		return v;
	endfunction

	// mostly a few busy rows with few columns so rows fill, hit and saturate
	function automatic sras_req_t rand_request(input int base);
		sras_req_t r;
		r.op = ($urandom_range(0, 99) < 35) ? OP_READ : OP_ACC;
		if ($urandom_range(0, 99) < 75) begin
			r.row = ROW_W'(base + $urandom_range(0, 5));
			r.col = COL_W'($urandom_range(0, 21));
		end else begin
			r.row = ROW_W'($urandom);
			r.col = COL_W'($urandom);
		end
		r.value = rand_amount();
		return r;
	endfunction

	task automatic send_req(input sras_req_t r);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [APB_DW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(REG_DROP_THR) << 3;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_thr = v[THR_W-1:0];
	endtask

	// result side: random stalls, one long hold-off when asked
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
			end else begin
				n = draw_wait();
			end
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [APB_DW-1:0] thr_plan [PHASES];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req_data = '0;
		sent = 0;
		hold_len = 0;
		steady = 1'b0;
		cur_thr = DROP_THR_RST;
		thr_plan[0] = 64'd1;
		thr_plan[1] = 64'd0;
		thr_plan[2] = {1'b0, {(VAL_W-1){1'b1}}};
		thr_plan[3] = {$urandom, $urandom};
		thr_plan[4] = 64'h1_0000_0000;
		thr_plan[5] = {1'b1, 63'($urandom_range(2, 65536))};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// exact zero dropped, absent read, new slot, saturation both ways
		send_req(mk_request(OP_ACC, 0, 0, 64'd0));
		send_req(mk_request(OP_READ, 0, 0, '1));
		send_req(mk_request(OP_ACC, 0, 5, 64'd1));
		send_req(mk_request(OP_ACC, 0, 5, {1'b0, {(VAL_W-1){1'b1}}}));
		send_req(mk_request(OP_READ, 0, 5, '0));
		send_req(mk_request(OP_ACC, 255, 255, {1'b1, {(VAL_W-1){1'b0}}}));
		send_req(mk_request(OP_ACC, 255, 255, {1'b1, {(VAL_W-1){1'b0}}}));
		send_req(mk_request(OP_READ, 255, 255, '0));
		// fill one row, then overflow it
		for (int i = 0; i < SLOTS_PER_ROW_DEF; i++) begin
			send_req(mk_request(OP_ACC, 2, i * 17, 64'(i + 1) << 32));
		end
		send_req(mk_request(OP_ACC, 2, 8, 64'd7));

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				write_threshold(thr_plan[p]);
			end
			steady = (p == 4);
			if (p == 2) begin
				hold_len = LONG_HOLD;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_req(rand_request(p * 8));
			end
		end

		wait_drained();
		repeat (SLOTS_PER_ROW_DEF + 8) @(posedge clk);
		$display("tb: %0d requests over %0d drop thresholds, %0d results compared",
			sent, PHASES, checked);
		if (fails == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== sparse_row_accumulate_store_top.f =====
+incdir+rtl
rtl/sras_pkg.sv
rtl/sras_ram.sv
rtl/sparse_row_accumulate_store_top.sv
bench/sras_checker.sv
bench/tb.sv
